/* rtl/mkd_pkg.sv */
// shared types, constants and code tables for the morse key decoder
package mkd_pkg;

    localparam int TICK_W           = 18;
    localparam int UNIT_W           = 16;
    localparam int CHAR_W           = 7;
    localparam int CODE_W           = 6;
    localparam int HIST_DEC_W       = 5;
    localparam int COUNT_DEC_W      = 4;
    localparam int MAX_ELEMENTS_DEF = 10;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TICK_W-1:0] TICK_MAX   = {TICK_W{1'b1}};
    localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd1000;
    localparam logic [CHAR_W-1:0] CHAR_QMARK = 7'd63;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'd32;
    localparam logic [CODE_W-1:0] CODE_NONE  = '0;

    // one decoded event handed from the timing front to the output back
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              msg_end;
        logic              ovf;
        logic              space;
    } t_event;

    // marker bit above the element bits, element 0 in bit 0, 1 = dash
    function automatic logic [CODE_W-1:0] pattern_code(
        input logic [HIST_DEC_W-1:0]  hist,
        input logic [COUNT_DEC_W-1:0] count
    );
        logic [CODE_W-1:0] code;
        unique case (count)
            4'd1:    code = {4'b0000, 1'b1, hist[0]};
            4'd2:    code = {3'b000, 1'b1, hist[1:0]};
            4'd3:    code = {2'b00, 1'b1, hist[2:0]};
            4'd4:    code = {1'b0, 1'b1, hist[3:0]};
            4'd5:    code = {1'b1, hist[4:0]};
            default: code = CODE_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [CHAR_W-1:0] morse_char(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        unique case (code)
            6'd6:    ch = 7'd65;  // A
            6'd17:   ch = 7'd66;  // B
            6'd21:   ch = 7'd67;  // C
            6'd9:    ch = 7'd68;  // D
            6'd2:    ch = 7'd69;  // E
            6'd20:   ch = 7'd70;  // F
            6'd11:   ch = 7'd71;  // G
            6'd16:   ch = 7'd72;  // H
            6'd4:    ch = 7'd73;  // I
            6'd30:   ch = 7'd74;  // J
            6'd13:   ch = 7'd75;  // K
            6'd18:   ch = 7'd76;  // L
            6'd7:    ch = 7'd77;  // M
            6'd5:    ch = 7'd78;  // N
            6'd15:   ch = 7'd79;  // O
            6'd22:   ch = 7'd80;  // P
            6'd27:   ch = 7'd81;  // Q
            6'd10:   ch = 7'd82;  // R
            6'd8:    ch = 7'd83;  // S
            6'd3:    ch = 7'd84;  // T
            6'd12:   ch = 7'd85;  // U
            6'd24:   ch = 7'd86;  // V
            6'd14:   ch = 7'd87;  // W
            6'd25:   ch = 7'd88;  // X
            6'd29:   ch = 7'd89;  // Y
            6'd19:   ch = 7'd90;  // Z
            6'd63:   ch = 7'd48;  // 0
            6'd62:   ch = 7'd49;  // 1
            6'd60:   ch = 7'd50;  // 2
            6'd56:   ch = 7'd51;  // 3
            6'd48:   ch = 7'd52;  // 4
            6'd32:   ch = 7'd53;  // 5
            6'd33:   ch = 7'd54;  // 6
            6'd35:   ch = 7'd55;  // 7
            6'd39:   ch = 7'd56;  // 8
            6'd47:   ch = 7'd57;  // 9
            default: ch = CHAR_QMARK;
        endcase
        return ch;
    endfunction

endpackage

/* rtl/mkd_front.sv */
// key timing front: press and silence counters, element history, event classification
module mkd_front #(
    parameter int MAX_ELEMENTS = mkd_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mkd_pkg::UNIT_W-1:0]  i_cfg_data,
    input  logic                        i_accept,
    input  logic                        i_key_level,
    output logic                        o_ev_valid,
    output mkd_pkg::t_event             o_ev
);
    import mkd_pkg::*;

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_PRESS,
        PH_SILENT
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [TICK_W-1:0]       r_press, n_press;
    logic [TICK_W-1:0]       r_sil, n_sil;
    logic [MAX_ELEMENTS-1:0] r_hist, n_hist;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [UNIT_W-1:0]       r_u1;
    logic [UNIT_W:0]         r_u2;
    logic [UNIT_W+1:0]       r_u3;

    logic [UNIT_W-1:0]       cfg_unit;
    logic [TICK_W-1:0]       press_inc;
    logic [TICK_W-1:0]       sil_inc;
    logic [CODE_W-1:0]       cur_code;
    logic                    dash;
    logic                    ev_valid;
    t_event                  ev;

    // zero ticks per unit counts as one
    assign cfg_unit = (i_cfg_data == '0) ? UNIT_W'(1) : i_cfg_data;

    always_comb begin
        n_phase   = r_phase;
        n_press   = r_press;
        n_sil     = r_sil;
        n_hist    = r_hist;
        n_count   = r_count;
        ev_valid  = 1'b0;
        ev        = '0;
        press_inc = (r_press == TICK_MAX) ? r_press : r_press + TICK_W'(1);
        sil_inc   = (r_sil == TICK_MAX) ? r_sil : r_sil + TICK_W'(1);
        cur_code  = pattern_code(r_hist[HIST_DEC_W-1:0], COUNT_DEC_W'(r_count));
        dash      = (r_press >= TICK_W'(r_u2));
        if (i_accept) begin
            unique case (r_phase)
                PH_PRESS: begin
                    if (i_key_level) begin
                        n_press = press_inc;
                    end else if (r_count >= CNT_W'(MAX_ELEMENTS)) begin
                        // too many elements: flag it and drop the character
                        ev_valid   = 1'b1;
                        ev.code    = CODE_NONE;
                        ev.msg_end = 1'b1;
                        ev.ovf     = 1'b1;
                        n_hist     = '0;
                        n_count    = '0;
                        n_phase    = PH_WAIT;
                        n_press    = '0;
                        n_sil      = '0;
                    end else begin
                        for (int i = 0; i < MAX_ELEMENTS; i++) begin
                            if (r_count == CNT_W'(i)) begin
                                n_hist[i] = dash;
                            end
                        end
                        n_count = r_count + CNT_W'(1);
                        n_phase = PH_SILENT;
                        n_press = '0;
                        n_sil   = TICK_W'(1);
                    end
                end
                PH_SILENT: begin
                    if (i_key_level) begin
                        if (r_sil >= TICK_W'(r_u1)) begin
                            ev_valid = 1'b1;
                            ev.code  = cur_code;
                            ev.space = (r_sil >= TICK_W'(r_u2));
                            n_hist   = '0;
                            n_count  = '0;
                        end
                        n_phase = PH_PRESS;
                        n_press = TICK_W'(1);
                        n_sil   = '0;
                    end else if (sil_inc >= TICK_W'(r_u3)) begin
                        ev_valid   = 1'b1;
                        ev.code    = cur_code;
                        ev.msg_end = 1'b1;
                        n_hist     = '0;
                        n_count    = '0;
                        n_phase    = PH_WAIT;
                        n_sil      = '0;
                    end else begin
                        n_sil = sil_inc;
                    end
                end
                default: begin
                    n_phase = PH_WAIT;
                    if (i_key_level) begin
                        n_phase = PH_PRESS;
                        n_press = TICK_W'(1);
                        n_sil   = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_press <= '0;
            r_sil   <= '0;
            r_hist  <= '0;
            r_count <= '0;
            r_u1    <= UNIT_RESET;
            r_u2    <= {UNIT_RESET, 1'b0};
            r_u3    <= {1'b0, UNIT_RESET, 1'b0} + {2'b00, UNIT_RESET};
        end else begin
            r_phase <= n_phase;
            r_press <= n_press;
            r_sil   <= n_sil;
            r_hist  <= n_hist;
            r_count <= n_count;
            // unit multiples kept ready so the compares need no adder
            if (i_cfg_we) begin
                r_u1 <= cfg_unit;
                r_u2 <= {cfg_unit, 1'b0};
                r_u3 <= {1'b0, cfg_unit, 1'b0} + {2'b00, cfg_unit};
            end
        end
    end

    assign o_ev_valid = ev_valid;
    assign o_ev       = ev;

endmodule

/* rtl/mkd_queue.sv */
// small event queue between the timing front and the output back
module mkd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mkd_pkg::t_event i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_head_valid,
    output mkd_pkg::t_event o_head
);
    import mkd_pkg::*;

    t_event              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full       = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd_ptr];

endmodule

/* rtl/mkd_back.sv */
// output back: character lookup, optional trailing space, registered result word
module mkd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_head_valid,
    input  mkd_pkg::t_event             i_head,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mkd_pkg::CHAR_W-1:0]  o_character,
    output logic                        o_message_end,
    output logic                        o_overflow_error,
    output logic                        o_last_of_run
);
    import mkd_pkg::*;

    logic              r_valid;
    logic              r_second;
    logic [CHAR_W-1:0] r_char;
    logic              r_end;
    logic              r_ovf;
    logic              r_last;
    logic              load;

    // the output register takes a new word when empty or being drained
    assign load  = !r_valid || !i_out_stall;
    assign o_pop = load && i_head_valid && (r_second || !i_head.space);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid <= i_head_valid;
            if (i_head_valid) begin
                r_second <= !r_second && i_head.space;
            end
        end
        if (load && i_head_valid) begin
            if (r_second) begin
                r_char <= CHAR_SPACE;
                r_end  <= 1'b0;
                r_ovf  <= 1'b0;
                r_last <= 1'b1;
            end else begin
                r_char <= morse_char(i_head.code);
                r_end  <= i_head.msg_end;
                r_ovf  <= i_head.ovf;
                r_last <= !i_head.space;
            end
        end
    end

    assign o_out_valid      = r_valid;
    assign o_character      = r_char;
    assign o_message_end    = r_end;
    assign o_overflow_error = r_ovf;
    assign o_last_of_run    = r_last;

endmodule

/* rtl/morse_key_decoder_unit.sv */
// morse key decoder top level: timing front, event queue, character back
//
//   channel | direction | handshake                | word
//   --------+-----------+--------------------------+------------------------------------
//   in      | in        | i_in_valid / o_in_stall  | i_key_level
//   out     | out       | o_out_valid / i_out_stall| o_character, o_message_end,
//           |           |                          | o_overflow_error, o_last_of_run
//   cfg     | in        | i_cfg_valid / o_cfg_ready| i_cfg_data (ticks per unit)
//
// one key sample is taken every cycle while i_in_valid is high and o_in_stall low;
// a result word is held in the event queue, then in the output register, and a
// character followed by a space takes two output words. a four-entry event queue
// between front and back absorbs output stalls; o_in_stall rises only when it is full.
// synchronous active-low reset; ticks per unit resets to 1000, cfg always ready.
module morse_key_decoder_unit #(
    parameter int MAX_ELEMENTS = mkd_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_key_level,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mkd_pkg::CHAR_W-1:0]  o_character,
    output logic                        o_message_end,
    output logic                        o_overflow_error,
    output logic                        o_last_of_run,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mkd_pkg::UNIT_W-1:0]  i_cfg_data
);
    import mkd_pkg::*;

    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_head_valid;
    t_event ev;
    t_event q_head;
    logic   in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !q_full;

    mkd_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_key_level (i_key_level),
        .o_ev_valid  (q_push),
        .o_ev        (ev)
    );

    mkd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_data       (ev),
        .i_pop        (q_pop),
        .o_full       (q_full),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    mkd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (q_head_valid),
        .i_head           (q_head),
        .o_pop            (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_character      (o_character),
        .o_message_end    (o_message_end),
        .o_overflow_error (o_overflow_error),
        .o_last_of_run    (o_last_of_run)
    );

    // an event is only produced on an accepted sample, so the queue never overruns
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("event pushed into a full queue");

    a_ovf_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow_error) |->
            (o_message_end && o_last_of_run && o_character == CHAR_QMARK))
        else $error("overflow word malformed");

    // a word that is not last of its run is always followed at once by the space
    a_space_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_of_run) |=>
            (o_out_valid && o_last_of_run && o_character == CHAR_SPACE))
        else $error("space word missing after character");

    a_first_of_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_of_run) |-> (!o_message_end && !o_overflow_error))
        else $error("message end on first word of a pair");

endmodule

/* dv/tb_top.sv */
// self-checking testbench for morse_key_decoder_unit: directed key runs, then random messages
module tb_top;

    localparam int          MAX_EL        = mkd_pkg::MAX_ELEMENTS_DEF;
    localparam int unsigned SAT_TICKS     = (1 << mkd_pkg::TICK_W) - 1;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_LIMIT   = 5000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS   = 100;
    localparam int unsigned MAX_PRINTS    = 40;
    localparam int          TIMEOUT_UNITS = 50_000_000;
    localparam int          PREDICTED     = -1;
    localparam int          HOLD_PHASE    = 0;
    localparam int          CALM_PHASE    = 2;
    localparam int          DRAIN_PHASE   = 4;
    localparam int unsigned RAND_UNITS [8] = '{1, 2, 3, 5, 1, 4, 8, 2};

    localparam logic [mkd_pkg::CHAR_W-1:0] CH_E    = 7'd69;
    localparam logic [mkd_pkg::CHAR_W-1:0] CH_T    = 7'd84;
    localparam logic [mkd_pkg::CHAR_W-1:0] CH_ZERO = 7'd48;

    typedef struct packed {
        logic [mkd_pkg::CHAR_W-1:0] ch;
        logic                       msg_end;
        logic                       ovf;
        logic                       last;
    } t_morse_word;

    typedef enum logic [1:0] {PH_IDLE, PH_DOWN, PH_UP} t_key_phase;
    typedef enum logic [1:0] {STEP_KEY, STEP_TAP, STEP_UNIT} t_step_kind;

    typedef struct {
        t_step_kind  kind;
        int unsigned value;
        int unsigned reps;
        int          n_fixed;
        t_morse_word w0;
        t_morse_word w1;
    } t_key_step;

    logic                        i_clk            = 1'b0;
    logic                        i_rst_n          = 1'b0;
    logic                        i_in_valid       = 1'b0;
    logic                        o_in_stall;
    logic                        i_key_level      = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_stall      = 1'b0;
    logic [mkd_pkg::CHAR_W-1:0]  o_character;
    logic                        o_message_end;
    logic                        o_overflow_error;
    logic                        o_last_of_run;
    logic                        i_cfg_valid      = 1'b0;
    logic                        o_cfg_ready;
    logic [mkd_pkg::UNIT_W-1:0]  i_cfg_data       = '0;

    // predictor state
    logic [mkd_pkg::UNIT_W-1:0]  unit_len  = mkd_pkg::UNIT_RESET;
    t_key_phase                  key_phase = PH_IDLE;
    int unsigned                 press_cnt = 0;
    int unsigned                 gap_cnt   = 0;
    logic [MAX_EL-1:0]           elem_bits = '0;
    int unsigned                 elem_n    = 0;

    t_morse_word expected_words[$];
    t_morse_word tick_words[$];
    t_key_step   steps[$];

    int unsigned fail_count = 0;
    int unsigned words_seen = 0;
    int unsigned items_sent = 0;
    bit          fixed_row  = 1'b0;
    bit          calm       = 1'b0;
    bit          hold_req   = 1'b0;

    string morse_patterns [36] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
        ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
        "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-", ".....", "-....",
        "--...", "---..", "----."
    };

    morse_key_decoder_unit #(
        .MAX_ELEMENTS(MAX_EL)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_key_level      (i_key_level),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_character      (o_character),
        .o_message_end    (o_message_end),
        .o_overflow_error (o_overflow_error),
        .o_last_of_run    (o_last_of_run),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_morse_word fixed_word(
        input logic [mkd_pkg::CHAR_W-1:0] ch,
        input logic                       msg_end,
        input logic                       ovf,
        input logic                       last
    );
        t_morse_word w;
        w.ch      = ch;
        w.msg_end = msg_end;
        w.ovf     = ovf;
        w.last    = last;
        return w;
    endfunction

    function automatic t_key_step key_step(
        input t_step_kind  kind,
        input int unsigned value,
        input int unsigned reps,
        input int          n_fixed = PREDICTED,
        input t_morse_word w0 = '0,
        input t_morse_word w1 = '0
    );
        t_key_step s;
        s.kind    = kind;
        s.value   = value;
        s.reps    = reps;
        s.n_fixed = n_fixed;
        s.w0      = w0;
        s.w1      = w1;
        return s;
    endfunction

    function automatic logic [mkd_pkg::CHAR_W-1:0] glyph_of_elements();
        string       pat;
        int unsigned code;
        if (elem_n < 1 || elem_n > 5)
            return mkd_pkg::CHAR_QMARK;
        pat = "";
        for (int i = 0; i < elem_n; i++) begin
            if (elem_bits[i])
                pat = {pat, "-"};
            else
                pat = {pat, "."};
        end
        for (int k = 0; k < 36; k++) begin
            if (pat == morse_patterns[k]) begin
                // letters first, then digits
                code = (k < 26) ? 65 + k : 22 + k;
                return code[mkd_pkg::CHAR_W-1:0];
            end
        end
        return mkd_pkg::CHAR_QMARK;
    endfunction

    function automatic void clear_elements();
        elem_bits = '0;
        elem_n    = 0;
    endfunction

    // words that one key sample produces, left in tick_words
    function automatic void morse_tick(input logic key);
        int unsigned u;
        logic        dash;
        tick_words.delete();
        u = (unit_len == 0) ? 1 : unit_len;
        case (key_phase)
            PH_DOWN: begin
                if (key) begin
                    if (press_cnt < SAT_TICKS)
                        press_cnt++;
                end else begin
                    dash      = (press_cnt >= 2 * u);
                    press_cnt = 0;
                    if (elem_n >= MAX_EL) begin
                        tick_words.push_back(
                            fixed_word(mkd_pkg::CHAR_QMARK, 1'b1, 1'b1, 1'b0));
                        clear_elements();
                        key_phase = PH_IDLE;
                        gap_cnt   = 0;
                    end else begin
                        elem_bits[elem_n] = dash;
                        elem_n++;
                        key_phase = PH_UP;
                        gap_cnt   = 1;
                    end
                end
            end
            PH_UP: begin
                if (key) begin
                    if (gap_cnt >= u) begin
                        tick_words.push_back(fixed_word(glyph_of_elements(), 1'b0, 1'b0, 1'b0));
                        clear_elements();
                        if (gap_cnt >= 2 * u)
                            tick_words.push_back(
                                fixed_word(mkd_pkg::CHAR_SPACE, 1'b0, 1'b0, 1'b0));
                    end
                    key_phase = PH_DOWN;
                    press_cnt = 1;
                    gap_cnt   = 0;
                end else begin
                    if (gap_cnt < SAT_TICKS)
                        gap_cnt++;
                    if (gap_cnt >= 3 * u) begin
                        tick_words.push_back(fixed_word(glyph_of_elements(), 1'b1, 1'b0, 1'b0));
                        clear_elements();
                        key_phase = PH_IDLE;
                        gap_cnt   = 0;
                    end
                end
            end
            default: begin
                if (key) begin
                    key_phase = PH_DOWN;
                    press_cnt = 1;
                    gap_cnt   = 0;
                end
            end
        endcase
        if (tick_words.size() != 0)
            tick_words[tick_words.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTS)
            $display("mismatch: %s", msg);
        fail_count++;
    endtask

    // one key sample; called at a rising edge, returns at the edge that took it
    task automatic send_sample(input logic key);
        logic took;
        while (!calm && $urandom_range(0, 99) < 11) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_key_level <= key;
        morse_tick(key);
        if (!fixed_row)
            foreach (tick_words[i])
                expected_words.push_back(tick_words[i]);
        do begin
            @(negedge i_clk);
            took = !o_in_stall;
            @(posedge i_clk);
        end while (!took);
        items_sent++;
    endtask

    task automatic key_run(input logic key, input int unsigned reps);
        repeat (reps) send_sample(key);
    endtask

    task automatic wait_drained();
        int unsigned waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_words.size() != 0) begin
            report_mismatch($sformatf("%0d predicted words never arrived",
                                      expected_words.size()));
            expected_words.delete();
        end
        // last sample may still be in flight without a word
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_unit(input logic [mkd_pkg::UNIT_W-1:0] v);
        logic took;
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do begin
            @(negedge i_clk);
            took = o_cfg_ready;
            @(posedge i_clk);
        end while (!took);
        i_cfg_valid <= 1'b0;
        unit_len = v;
    endtask

    function automatic int unsigned press_len(input int unsigned u);
        case ($urandom_range(0, 7))
            0:       return 2 * u - 1;   // longest dot
            1:       return 2 * u;       // shortest dash
            2, 3, 4: return $urandom_range(1, 2 * u - 1);
            default: return $urandom_range(2 * u, 3 * u);
        endcase
    endfunction

    task automatic send_message();
        int unsigned u;
        int unsigned n_chars;
        int unsigned n_el;
        int unsigned pick;
        u = (unit_len == 0) ? 1 : unit_len;
        // noise: random runs of either level
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(4, 30))
                key_run($urandom_range(0, 1) == 1, $urandom_range(1, 4 * u));
            return;
        end
        n_chars = $urandom_range(1, 4);
        for (int c = 0; c < n_chars; c++) begin
            pick = $urandom_range(0, 19);
            if (pick < 16)
                n_el = $urandom_range(1, 5);
            else if (pick < 18)
                n_el = $urandom_range(6, MAX_EL - 1);
            else
                n_el = $urandom_range(MAX_EL, MAX_EL + 1);
            for (int e = 0; e < n_el; e++) begin
                key_run(1'b1, press_len(u));
                if (e < n_el - 1)
                    key_run(1'b0, (u > 1) ? $urandom_range(1, u - 1) : 1);
            end
            if (c < n_chars - 1) begin
                if ($urandom_range(0, 1) == 1)
                    key_run(1'b0, $urandom_range(u, 2 * u - 1));
                else
                    key_run(1'b0, $urandom_range(2 * u, 3 * u - 1));
            end
        end
        key_run(1'b0, $urandom_range(3 * u, 3 * u + 4));
    endtask

    // output side: compare every taken word with the oldest prediction
    always @(negedge i_clk) begin : out_check
        t_morse_word got;
        t_morse_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_character, o_message_end, o_overflow_error, o_last_of_run};
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("word %0d arrived with nothing predicted (char %0d)",
                                          words_seen, got.ch));
            end else begin
                want = expected_words.pop_front();
                if (got.ch != want.ch)
                    report_mismatch($sformatf("word %0d character %0d, predicted %0d",
                                              words_seen, got.ch, want.ch));
                if (got.msg_end != want.msg_end)
                    report_mismatch($sformatf("word %0d message_end %0b, predicted %0b",
                                              words_seen, got.msg_end, want.msg_end));
                if (got.ovf != want.ovf)
                    report_mismatch($sformatf("word %0d overflow_error %0b, predicted %0b",
                                              words_seen, got.ovf, want.ovf));
                if (got.last != want.last)
                    report_mismatch($sformatf("word %0d last_of_run %0b, predicted %0b",
                                              words_seen, got.last, want.last));
            end
            words_seen++;
        end
    end

    initial begin : stall_drive
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= !calm && ($urandom_range(0, 99) < 11);
        end
    end

    initial begin
        #(TIMEOUT_UNITS);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase_mark;
        bit          paused;

        // silence before the first press, then a dot and a character gap at the reset unit
        steps.push_back(key_step(STEP_KEY, 0, 5, 0));
        steps.push_back(key_step(STEP_KEY, 1, 1));
        steps.push_back(key_step(STEP_KEY, 0, 1000));
        steps.push_back(key_step(STEP_KEY, 1, 1, 1, fixed_word(CH_E, 1'b0, 1'b0, 1'b1)));
        // zero unit behaves as one
        steps.push_back(key_step(STEP_UNIT, 0, 1));
        steps.push_back(key_step(STEP_KEY, 0, 3, 1, fixed_word(CH_E, 1'b1, 1'b0, 1'b1)));
        steps.push_back(key_step(STEP_KEY, 1, 1));
        steps.push_back(key_step(STEP_KEY, 0, 3, 1, fixed_word(CH_E, 1'b1, 1'b0, 1'b1)));
        // character end, then character plus space, then message end
        steps.push_back(key_step(STEP_UNIT, 1, 1));
        steps.push_back(key_step(STEP_KEY, 1, 2));
        steps.push_back(key_step(STEP_KEY, 0, 1));
        steps.push_back(key_step(STEP_KEY, 1, 1, 1, fixed_word(CH_T, 1'b0, 1'b0, 1'b1)));
        steps.push_back(key_step(STEP_KEY, 0, 2));
        steps.push_back(key_step(STEP_KEY, 1, 1, 2, fixed_word(CH_E, 1'b0, 1'b0, 1'b0),
                                 fixed_word(mkd_pkg::CHAR_SPACE, 1'b0, 1'b0, 1'b1)));
        steps.push_back(key_step(STEP_KEY, 0, 3, 1, fixed_word(CH_E, 1'b1, 1'b0, 1'b1)));
        // one element too many, then ignored silence
        steps.push_back(key_step(STEP_UNIT, 3, 1));
        steps.push_back(key_step(STEP_TAP, 1, MAX_EL));
        steps.push_back(key_step(STEP_KEY, 1, 1));
        steps.push_back(key_step(STEP_KEY, 0, 1, 1,
                                 fixed_word(mkd_pkg::CHAR_QMARK, 1'b1, 1'b1, 1'b1)));
        steps.push_back(key_step(STEP_KEY, 0, 10, 0));
        // six elements decode as unknown, five dashes as a digit
        steps.push_back(key_step(STEP_TAP, 1, 6));
        steps.push_back(key_step(STEP_KEY, 0, 8, 1,
                                 fixed_word(mkd_pkg::CHAR_QMARK, 1'b1, 1'b0, 1'b1)));
        steps.push_back(key_step(STEP_TAP, 6, 5));
        steps.push_back(key_step(STEP_KEY, 0, 8, 1, fixed_word(CH_ZERO, 1'b1, 1'b0, 1'b1)));
        // at the largest unit a three tick press is still a dot
        steps.push_back(key_step(STEP_UNIT, 16'hFFFF, 1));
        steps.push_back(key_step(STEP_KEY, 1, 3));
        steps.push_back(key_step(STEP_KEY, 0, 1));
        steps.push_back(key_step(STEP_UNIT, 1, 1));
        steps.push_back(key_step(STEP_KEY, 0, 2, 1, fixed_word(CH_E, 1'b1, 1'b0, 1'b1)));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[i]) begin
            fixed_row = (steps[i].n_fixed != PREDICTED);
            case (steps[i].kind)
                STEP_UNIT: begin
                    wait_drained();
                    write_unit(steps[i].value[mkd_pkg::UNIT_W-1:0]);
                end
                STEP_TAP: begin
                    repeat (steps[i].reps) begin
                        key_run(1'b1, steps[i].value);
                        key_run(1'b0, 1);
                    end
                end
                default: key_run(steps[i].value[0], steps[i].reps);
            endcase
            if (steps[i].n_fixed > 0)
                expected_words.push_back(steps[i].w0);
            if (steps[i].n_fixed > 1)
                expected_words.push_back(steps[i].w1);
            fixed_row = 1'b0;
        end

        paused = 1'b0;
        for (int p = 0; p < 8; p++) begin
            wait_drained();
            write_unit(RAND_UNITS[p][mkd_pkg::UNIT_W-1:0]);
            calm = (p == CALM_PHASE);
            // long output hold while samples keep coming, to fill the event queue
            if (p == HOLD_PHASE)
                hold_req = 1'b1;
            phase_mark = items_sent;
            while (items_sent - phase_mark < PHASE_ITEMS) begin
                send_message();
                if (p == DRAIN_PHASE && !paused) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end
        calm = 1'b0;

        wait_drained();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
